>>> sv/slcfd_pkg.sv
// slcfd_pkg: shared types, status codes and the crc-8 step for the frame decoder
// used by every module of sync_length_crc8_frame_decoder; depends on nothing

package slcfd_pkg;

  // largest payload the frame format can describe (length byte minus two)
  localparam logic [7:0] MAX_PAYLOAD = 8'd253;

  // frame layout positions
  localparam logic [8:0] POS_SYNC     = 9'd0;
  localparam logic [8:0] POS_LENGTH   = 9'd1;
  localparam logic [8:0] POS_SEQ      = 9'd2;
  localparam logic [8:0] POS_PAYLOAD  = 9'd4;
  localparam logic [8:0] POS_SATURATE = 9'd511;

  // bytes of overhead counted in the length byte
  localparam logic [7:0] LEN_OVERHEAD = 8'd2;

  // crc-8 polynomial, msb first
  localparam logic [7:0] CRC_POLY = 8'h07;

  // configuration register indexes
  localparam logic [7:0] REG_MAX_PAYLOAD = 8'd0;
  localparam logic [7:0] REG_SYNC_BYTE   = 8'd1;

  // configuration reset values
  localparam logic [7:0] MAX_PAYLOAD_RST = 8'd253;
  localparam logic [7:0] SYNC_BYTE_RST   = 8'd170;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_IDLE  = 3'd1,
    ST_TRUNC = 3'd2,
    ST_SYNC  = 3'd3,
    ST_LEN   = 3'd4,
    ST_CRC   = 3'd5
  } status_t;

  // configuration values seen by the parser
  typedef struct packed {
    logic [7:0] payload_limit;
    logic [7:0] sync_byte;
  } cfg_t;

  // one result beat
  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       status_valid;
    status_t    status;
    logic [7:0] message_seq;
    logic [7:0] message_type;
    logic [7:0] payload_length;
  } result_t;

  // one byte of crc-8 update, init 0, no final xor
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> sv/slcfd_cfg_regs.sv
// slcfd_cfg_regs: configuration registers written through the valid/ready config port
// depends on slcfd_pkg for register indexes, reset values and cfg_t

module slcfd_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  output slcfd_pkg::cfg_t     cfg
);

  logic [7:0] payload_limit;
  logic [7:0] sync_byte;

  // writes are always taken
  assign cfg_ready = 1'b1;

  // register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      payload_limit <= slcfd_pkg::MAX_PAYLOAD_RST;
      sync_byte     <= slcfd_pkg::SYNC_BYTE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        slcfd_pkg::REG_MAX_PAYLOAD: payload_limit <= cfg_data;
        slcfd_pkg::REG_SYNC_BYTE:   sync_byte     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg.payload_limit = payload_limit;
  assign cfg.sync_byte     = sync_byte;

endmodule

>>> sv/slcfd_parser.sv
// slcfd_parser: per-buffer frame state and the checks made on each byte
// depends on slcfd_pkg for status codes, cfg_t, result_t and crc8_update

module slcfd_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           rx_byte,
  input  logic                 buffer_end,
  input  slcfd_pkg::cfg_t      cfg,
  output logic                 has_result,
  output slcfd_pkg::result_t   result
);

  // frame state
  logic [8:0] byte_position;
  logic       first_matched_sync;
  logic [7:0] length_field;
  logic [7:0] seq_hold;
  logic [7:0] type_hold;
  logic [7:0] running_crc;
  logic       status_sent;

  logic [8:0] byte_position_next;
  logic       first_matched_sync_next;
  logic [7:0] length_field_next;
  logic [7:0] seq_hold_next;
  logic [7:0] type_hold_next;
  logic [7:0] running_crc_next;
  logic       status_sent_next;

  logic [7:0]          crc_step;
  logic [7:0]          pay_len;
  logic [8:0]          pay_end;
  logic                pv;
  logic                sv;
  slcfd_pkg::status_t  st;

  assign crc_step = slcfd_pkg::crc8_update(running_crc, rx_byte);
  assign pay_len  = (length_field >= slcfd_pkg::LEN_OVERHEAD) ?
                    (length_field - slcfd_pkg::LEN_OVERHEAD) : 8'd0;
  assign pay_end  = slcfd_pkg::POS_PAYLOAD + {1'b0, pay_len};

  // decision for the current byte and next frame state
  always_comb begin
    pv = 1'b0;
    sv = 1'b0;
    st = slcfd_pkg::ST_OK;
    first_matched_sync_next = first_matched_sync;
    length_field_next       = length_field;
    seq_hold_next           = seq_hold;
    type_hold_next          = type_hold;
    running_crc_next        = running_crc;

    if (status_sent) begin
      // drop bytes until the buffer ends
    end else if (cfg.payload_limit > slcfd_pkg::MAX_PAYLOAD) begin
      sv = 1'b1;
      st = slcfd_pkg::ST_LEN;
    end else if (byte_position == slcfd_pkg::POS_SYNC) begin
      if (rx_byte == 8'd0) begin
        sv = 1'b1;
        st = slcfd_pkg::ST_IDLE;
      end else begin
        first_matched_sync_next = (rx_byte == cfg.sync_byte);
        if (buffer_end) begin
          sv = 1'b1;
          st = slcfd_pkg::ST_TRUNC;
        end
      end
    end else if (byte_position < slcfd_pkg::POS_PAYLOAD) begin
      // header bytes feed the crc
      if (byte_position == slcfd_pkg::POS_LENGTH) begin
        length_field_next = rx_byte;
      end else if (byte_position == slcfd_pkg::POS_SEQ) begin
        seq_hold_next = rx_byte;
      end else begin
        type_hold_next = rx_byte;
      end
      running_crc_next = crc_step;
      if (buffer_end) begin
        sv = 1'b1;
        st = slcfd_pkg::ST_TRUNC;
      end
    end else if (byte_position == slcfd_pkg::POS_PAYLOAD && !first_matched_sync) begin
      sv = 1'b1;
      st = slcfd_pkg::ST_SYNC;
    end else if (byte_position == slcfd_pkg::POS_PAYLOAD &&
                 (length_field < slcfd_pkg::LEN_OVERHEAD || pay_len > cfg.payload_limit)) begin
      sv = 1'b1;
      st = slcfd_pkg::ST_LEN;
    end else if (byte_position < pay_end) begin
      // payload streams out ahead of the crc check
      pv = 1'b1;
      running_crc_next = crc_step;
      if (buffer_end) begin
        sv = 1'b1;
        st = slcfd_pkg::ST_TRUNC;
      end
    end else begin
      sv = 1'b1;
      st = (rx_byte == running_crc) ? slcfd_pkg::ST_OK : slcfd_pkg::ST_CRC;
    end

    status_sent_next   = status_sent | sv;
    byte_position_next = (byte_position == slcfd_pkg::POS_SATURATE) ?
                         byte_position : byte_position + 9'd1;
  end

  // result fields, zero where not meaningful
  always_comb begin
    has_result            = pv | sv;
    result.payload_valid  = pv;
    result.payload_byte   = pv ? rx_byte : 8'd0;
    result.status_valid   = sv;
    result.status         = sv ? st : slcfd_pkg::ST_OK;
    if (sv && st == slcfd_pkg::ST_OK) begin
      result.message_seq    = seq_hold;
      result.message_type   = type_hold;
      result.payload_length = length_field - slcfd_pkg::LEN_OVERHEAD;
    end else begin
      result.message_seq    = 8'd0;
      result.message_type   = 8'd0;
      result.payload_length = 8'd0;
    end
  end

  // frame state registers; buffer end clears everything
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position      <= 9'd0;
      first_matched_sync <= 1'b0;
      length_field       <= 8'd0;
      seq_hold           <= 8'd0;
      type_hold          <= 8'd0;
      running_crc        <= 8'd0;
      status_sent        <= 1'b0;
    end else if (step) begin
      if (buffer_end) begin
        byte_position      <= 9'd0;
        first_matched_sync <= 1'b0;
        length_field       <= 8'd0;
        seq_hold           <= 8'd0;
        type_hold          <= 8'd0;
        running_crc        <= 8'd0;
        status_sent        <= 1'b0;
      end else begin
        byte_position      <= byte_position_next;
        first_matched_sync <= first_matched_sync_next;
        length_field       <= length_field_next;
        seq_hold           <= seq_hold_next;
        type_hold          <= type_hold_next;
        running_crc        <= running_crc_next;
        status_sent        <= status_sent_next;
      end
    end
  end

endmodule

>>> sv/slcfd_out_reg.sv
// slcfd_out_reg: result register holding one beat until the sink takes it
// depends on slcfd_pkg for result_t

module slcfd_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  slcfd_pkg::result_t  load_data,
  output logic                free,
  output logic                out_valid,
  input  logic                out_stall,
  output slcfd_pkg::result_t  out_data
);

  // slot can take a new beat when empty or being drained this cycle
  assign free = !out_valid || !out_stall;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (free && load) begin
      out_data <= load_data;
    end
  end

endmodule

>>> sv/sync_length_crc8_frame_decoder.sv
// sync_length_crc8_frame_decoder: top level with input register, parser and result register
// depends on slcfd_pkg, slcfd_cfg_regs, slcfd_parser and slcfd_out_reg
//
//   port group   handshake              payload
//   ----------   --------------------   --------------------------------------------
//   input        in_valid / in_stall    rx_byte, buffer_end
//   result       out_valid / out_stall  payload_valid, payload_byte, status_valid,
//                                       status, message_seq, message_type,
//                                       payload_length
//   config       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one byte per cycle sustained while out_stall is low; a byte taken goes to the input register,
// then through the crc-8 step and position compare into the result register
// rst is synchronous; it empties both registers, clears the frame state and loads
// payload limit 253 and sync_byte 170
// out_stall holds the result register; while it is full and stalled, in_stall rises as soon as
// the input register is occupied, whether or not the held byte gives a result
// cfg_ready is always high

module sync_length_crc8_frame_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       buffer_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       payload_valid,
  output logic [7:0] payload_byte,
  output logic       status_valid,
  output logic [2:0] status,
  output logic [7:0] message_seq,
  output logic [7:0] message_type,
  output logic [7:0] payload_length,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data
);

  slcfd_pkg::cfg_t    cfg;
  slcfd_pkg::result_t step_result;
  slcfd_pkg::result_t out_data;

  logic       in_q_valid;
  logic [7:0] in_q_byte;
  logic       in_q_end;
  logic       step;
  logic       has_result;
  logic       out_free;
  logic       in_take;

  // a held byte moves on once the result slot is free
  assign step     = in_q_valid && out_free;
  assign in_stall = in_q_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_take) begin
      in_q_valid <= 1'b1;
    end else if (step) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_q_byte <= rx_byte;
      in_q_end  <= buffer_end;
    end
  end

  slcfd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  slcfd_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .rx_byte    (in_q_byte),
    .buffer_end (in_q_end),
    .cfg        (cfg),
    .has_result (has_result),
    .result     (step_result)
  );

  slcfd_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step && has_result),
    .load_data (step_result),
    .free      (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // result fields to ports
  assign payload_valid  = out_data.payload_valid;
  assign payload_byte   = out_data.payload_byte;
  assign status_valid   = out_data.status_valid;
  assign status         = out_data.status;
  assign message_seq    = out_data.message_seq;
  assign message_type   = out_data.message_type;
  assign payload_length = out_data.payload_length;

endmodule

>>> dv/sync_length_crc8_frame_decoder_tb.sv
// sync_length_crc8_frame_decoder_tb: self-checking bench for the framed crc-8 receiver
// depends on slcfd_pkg and sync_length_crc8_frame_decoder; a directed table, then random
// buffers over several register settings, each beat checked against a predictor or typed row

module sync_length_crc8_frame_decoder_tb;

  localparam int MAX_IDLE       = 18;
  localparam int LONG_HOLD      = 120;
  localparam int DRAIN_TAIL     = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REG_COUNT      = 2;

  // one row of the directed table; typed rows carry their status, the rest use the predictor
  typedef struct packed {
    logic [7:0]         rx;
    logic               last;
    logic               typed;
    slcfd_pkg::status_t st;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [24] = '{
    // zero first byte on a one-byte buffer
    '{8'h00, 1'b1, 1'b1, slcfd_pkg::ST_IDLE},
    // zero first byte, then a byte that is ignored up to the buffer end
    '{8'h00, 1'b0, 1'b1, slcfd_pkg::ST_IDLE},
    '{8'hFF, 1'b1, 1'b0, slcfd_pkg::ST_OK},
    // buffer ends on the sync byte
    '{8'hAA, 1'b1, 1'b1, slcfd_pkg::ST_TRUNC},
    // wrong sync, reported on the fifth byte
    '{8'h55, 1'b0, 1'b0, slcfd_pkg::ST_OK},
    '{8'h02, 1'b0, 1'b0, slcfd_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, slcfd_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, slcfd_pkg::ST_OK},
    '{8'h00, 1'b1, 1'b1, slcfd_pkg::ST_SYNC},
    // length byte below the overhead
    '{8'hAA, 1'b0, 1'b0, slcfd_pkg::ST_OK},
    '{8'h01, 1'b0, 1'b0, slcfd_pkg::ST_OK},
    '{8'hFF, 1'b0, 1'b0, slcfd_pkg::ST_OK},
    '{8'hFF, 1'b0, 1'b0, slcfd_pkg::ST_OK},
    '{8'hFF, 1'b1, 1'b1, slcfd_pkg::ST_LEN},
    // empty payload with a good crc
    '{8'hAA, 1'b0, 1'b0, slcfd_pkg::ST_OK},
    '{8'h02, 1'b0, 1'b0, slcfd_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, slcfd_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, slcfd_pkg::ST_OK},
    '{8'hD6, 1'b1, 1'b0, slcfd_pkg::ST_OK},
    // buffer ends on a payload byte
    '{8'hAA, 1'b0, 1'b0, slcfd_pkg::ST_OK},
    '{8'h03, 1'b0, 1'b0, slcfd_pkg::ST_OK},
    '{8'h80, 1'b0, 1'b0, slcfd_pkg::ST_OK},
    '{8'h7F, 1'b0, 1'b0, slcfd_pkg::ST_OK},
    '{8'h01, 1'b1, 1'b0, slcfd_pkg::ST_OK}
  };

  // register settings walked after the default one
  localparam slcfd_pkg::cfg_t PHASE_CFG [5] = '{
    '{8'd0,   8'hFF},
    '{8'd255, 8'h00},
    '{8'd254, 8'h01},
    '{8'd7,   8'h3C},
    '{8'd253, 8'hAA}
  };

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] rx_byte;
  logic       buffer_end;
  logic       out_valid;
  logic       out_stall;
  logic       payload_valid;
  logic [7:0] payload_byte;
  logic       status_valid;
  logic [2:0] status;
  logic [7:0] message_seq;
  logic [7:0] message_type;
  logic [7:0] payload_length;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_index;
  logic [7:0] cfg_data;

  // typed expectation travelling with the current input beat
  logic               row_typed;
  slcfd_pkg::status_t row_status;

  // predictor copy of the registers and of the per-buffer frame state
  logic [7:0] cfg_payload_limit;
  logic [7:0] cfg_sync_byte;
  logic [8:0] frame_pos;
  logic       frame_sync_hit;
  logic [7:0] frame_length_byte;
  logic [7:0] frame_seq;
  logic [7:0] frame_type;
  logic [7:0] frame_crc;
  logic       frame_done;

  slcfd_pkg::result_t decoder_beats[$];
  int         mismatches = 0;
  int         quiet_cycles = 0;
  bit         hold_request = 1'b0;
  bit         source_burst = 1'b0;
  bit         sink_burst = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sync_length_crc8_frame_decoder dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .rx_byte        (rx_byte),
    .buffer_end     (buffer_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .payload_valid  (payload_valid),
    .payload_byte   (payload_byte),
    .status_valid   (status_valid),
    .status         (status),
    .message_seq    (message_seq),
    .message_type   (message_type),
    .payload_length (payload_length),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // crc-8, poly 0x07, shifted in one data bit at a time, msb first
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      if (c[7] ^ data[i]) begin
        c = {c[6:0], 1'b0} ^ slcfd_pkg::CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic void clear_frame();
    frame_pos         = '0;
    frame_sync_hit    = 1'b0;
    frame_length_byte = '0;
    frame_seq         = '0;
    frame_type        = '0;
    frame_crc         = '0;
    frame_done        = 1'b0;
  endfunction

  // advance the frame state by one buffer byte; returns 1 when the byte gives a result beat
  function automatic logic decode_rx_byte(input logic [7:0] rx, input logic last,
                                          output slcfd_pkg::result_t beat);
    logic [8:0]         pos;
    logic [7:0]         pl;
    logic               pv;
    logic               sv;
    slcfd_pkg::status_t st;
    pos  = frame_pos;
    pv   = 1'b0;
    sv   = 1'b0;
    st   = slcfd_pkg::ST_OK;
    beat = '0;
    // status already given: swallow the rest of the buffer
    if (frame_done) begin
      if (last) clear_frame();
      return 1'b0;
    end
    if (cfg_payload_limit > slcfd_pkg::MAX_PAYLOAD) begin
      sv = 1'b1;
      st = slcfd_pkg::ST_LEN;
    end else if (pos == slcfd_pkg::POS_SYNC) begin
      if (rx == 8'h00) begin
        sv = 1'b1;
        st = slcfd_pkg::ST_IDLE;
      end else begin
        frame_sync_hit = (rx == cfg_sync_byte);
        if (last) begin
          sv = 1'b1;
          st = slcfd_pkg::ST_TRUNC;
        end
      end
    end else if (pos < slcfd_pkg::POS_PAYLOAD) begin
      // header bytes covered by the crc
      if (pos == slcfd_pkg::POS_LENGTH) frame_length_byte = rx;
      else if (pos == slcfd_pkg::POS_SEQ) frame_seq = rx;
      else frame_type = rx;
      frame_crc = crc8_step(frame_crc, rx);
      if (last) begin
        sv = 1'b1;
        st = slcfd_pkg::ST_TRUNC;
      end
    end else begin
      pl = (frame_length_byte >= slcfd_pkg::LEN_OVERHEAD) ?
           frame_length_byte - slcfd_pkg::LEN_OVERHEAD : 8'd0;
      if (pos == slcfd_pkg::POS_PAYLOAD && !frame_sync_hit) begin
        sv = 1'b1;
        st = slcfd_pkg::ST_SYNC;
      end else if (pos == slcfd_pkg::POS_PAYLOAD &&
                   (frame_length_byte < slcfd_pkg::LEN_OVERHEAD || pl > cfg_payload_limit)) begin
        sv = 1'b1;
        st = slcfd_pkg::ST_LEN;
      end else if (pos < slcfd_pkg::POS_PAYLOAD + {1'b0, pl}) begin
        pv = 1'b1;
        frame_crc = crc8_step(frame_crc, rx);
        if (last) begin
          sv = 1'b1;
          st = slcfd_pkg::ST_TRUNC;
        end
      end else begin
        sv = 1'b1;
        st = (rx == frame_crc) ? slcfd_pkg::ST_OK : slcfd_pkg::ST_CRC;
      end
    end
    beat.payload_valid = pv;
    beat.payload_byte  = pv ? rx : 8'h00;
    beat.status_valid  = sv;
    beat.status        = st;
    if (sv && st == slcfd_pkg::ST_OK) begin
      beat.message_seq    = frame_seq;
      beat.message_type   = frame_type;
      beat.payload_length = frame_length_byte - slcfd_pkg::LEN_OVERHEAD;
    end
    if (last) begin
      clear_frame();
    end else begin
      if (sv) frame_done = 1'b1;
      if (frame_pos != slcfd_pkg::POS_SATURATE) frame_pos = frame_pos + 9'd1;
    end
    return pv || sv;
  endfunction

  function automatic void compare_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic int idle_cycles(input bit burst);
    return burst ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  // check taken result beats, predict taken input beats, track register writes
  always @(posedge clk) begin : frame_check
    slcfd_pkg::result_t beat;
    logic               produced;
    if (rst) begin
      clear_frame();
      cfg_payload_limit = slcfd_pkg::MAX_PAYLOAD_RST;
      cfg_sync_byte     = slcfd_pkg::SYNC_BYTE_RST;
    end else begin
      // a beat taken now was predicted at an earlier edge
      if (out_valid && !out_stall) begin
        if (decoder_beats.size() == 0) begin
          $error("result beat with no prediction pending");
          mismatches++;
        end else begin
          beat = decoder_beats.pop_front();
          compare_field("payload_valid", 8'(beat.payload_valid), 8'(payload_valid));
          compare_field("payload_byte", beat.payload_byte, payload_byte);
          compare_field("status_valid", 8'(beat.status_valid), 8'(status_valid));
          compare_field("status", 8'(beat.status), 8'(status));
          compare_field("message_seq", beat.message_seq, message_seq);
          compare_field("message_type", beat.message_type, message_type);
          compare_field("payload_length", beat.payload_length, payload_length);
        end
      end
      if (in_valid && !in_stall) begin
        produced = decode_rx_byte(rx_byte, buffer_end, beat);
        if (row_typed) begin
          beat = '0;
          beat.status_valid = 1'b1;
          beat.status = row_status;
          produced = 1'b1;
        end
        if (produced) decoder_beats.push_back(beat);
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == slcfd_pkg::REG_MAX_PAYLOAD) cfg_payload_limit = cfg_data;
        else if (cfg_index == slcfd_pkg::REG_SYNC_BYTE) cfg_sync_byte = cfg_data;
      end
    end
  end

  // end the run when no channel moves a beat for too long
  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: random stall before each beat, bursts with none, one long hold on request
  initial begin : result_sink
    int hold;
    out_stall = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 47) == 0) sink_burst = !sink_burst;
      if (hold_request) begin
        hold_request = 1'b0;
        hold = LONG_HOLD;
      end else begin
        hold = idle_cycles(sink_burst);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // offer one input beat after a random gap and return at the edge that takes it
  task automatic send_byte(input logic [7:0] data, input logic last, input logic typed,
                           input slcfd_pkg::status_t st);
    int gap;
    if ($urandom_range(0, 47) == 0) source_burst = !source_burst;
    gap = idle_cycles(source_burst);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    rx_byte    <= data;
    buffer_end <= last;
    row_typed  <= typed;
    row_status <= st;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // stop offering, wait out every pending result and the bytes that give none
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (decoder_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  // one buffer: mostly a well-formed frame for the current settings, else damaged or noise
  task automatic send_frame(output int count);
    logic [7:0] frame_bytes[$];
    logic [7:0] crc;
    int         limit;
    int         plen;
    int         kind;
    int         cut;
    int         k;
    limit = (cfg_payload_limit > slcfd_pkg::MAX_PAYLOAD) ? slcfd_pkg::MAX_PAYLOAD :
            cfg_payload_limit;
    if ($urandom_range(0, 39) == 0) plen = limit;
    else plen = $urandom_range(0, (limit < 12) ? limit : 12);
    frame_bytes = {};
    frame_bytes.push_back(cfg_sync_byte);
    frame_bytes.push_back(8'(plen + 2));
    frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(8'($urandom));
    for (k = 0; k < plen; k++) frame_bytes.push_back(8'($urandom));
    crc = 8'h00;
    for (k = 1; k < frame_bytes.size(); k++) crc = crc8_step(crc, frame_bytes[k]);
    frame_bytes.push_back(crc);
    kind = $urandom_range(0, 99);
    if (kind >= 95) begin
      // random noise buffer
      frame_bytes = {};
      repeat ($urandom_range(1, 8)) frame_bytes.push_back(8'($urandom));
    end else if (kind >= 89) begin
      // bytes trailing the frame in the same buffer
      repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom));
    end else if (kind >= 84) begin
      frame_bytes[1] = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 1)) : 8'($urandom);
    end else if (kind >= 80) begin
      frame_bytes[0] = 8'h00;
    end else if (kind >= 73) begin
      cut = $urandom_range(1, frame_bytes.size() - 1);
      while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
    end else if (kind >= 65) begin
      k = $urandom_range(0, frame_bytes.size() - 1);
      frame_bytes[k] = frame_bytes[k] ^ 8'(1 << $urandom_range(0, 7));
    end
    for (k = 0; k < frame_bytes.size(); k++) begin
      send_byte(frame_bytes[k], k == frame_bytes.size() - 1, 1'b0, slcfd_pkg::ST_OK);
    end
    count = frame_bytes.size();
  endtask

  task automatic run_frames(input int item_goal, input int hold_at);
    int sent;
    int n;
    sent = 0;
    while (sent < item_goal) begin
      if (hold_at >= 0 && sent >= hold_at) begin
        hold_request = 1'b1;
        hold_at = -1;
      end
      send_frame(n);
      sent += n;
    end
  endtask

  // reset, directed table, then random buffers over each register setting
  initial begin : stimulus
    rst        = 1'b1;
    in_valid   = 1'b0;
    rx_byte    = 8'h00;
    buffer_end = 1'b0;
    row_typed  = 1'b0;
    row_status = slcfd_pkg::ST_OK;
    cfg_valid  = 1'b0;
    cfg_index  = 8'h00;
    cfg_data   = 8'h00;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_ROWS[r]) begin
      send_byte(DIRECTED_ROWS[r].rx, DIRECTED_ROWS[r].last, DIRECTED_ROWS[r].typed,
                DIRECTED_ROWS[r].st);
    end
    run_frames(330, 120);

    // each setting also gets a write to an unmapped index that must change nothing
    foreach (PHASE_CFG[p]) begin
      settle();
      write_reg(slcfd_pkg::REG_MAX_PAYLOAD, PHASE_CFG[p].payload_limit);
      write_reg(slcfd_pkg::REG_SYNC_BYTE, PHASE_CFG[p].sync_byte);
      write_reg(8'($urandom_range(REG_COUNT, 255)), 8'($urandom));
      run_frames(200, -1);
    end
    settle();
    write_reg(slcfd_pkg::REG_MAX_PAYLOAD, 8'($urandom_range(1, slcfd_pkg::MAX_PAYLOAD)));
    write_reg(slcfd_pkg::REG_SYNC_BYTE, 8'($urandom_range(1, 255)));
    run_frames(250, -1);
    settle();

    if (mismatches == 0 && decoder_beats.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
sv/slcfd_pkg.sv
sv/slcfd_cfg_regs.sv
sv/slcfd_parser.sv
sv/slcfd_out_reg.sv
sv/sync_length_crc8_frame_decoder.sv
dv/sync_length_crc8_frame_decoder_tb.sv
